// ===== rtl/peq_pkg.sv =====
// Shared types and constants of the priority EDF ready queue.
package peq_pkg;
	localparam int IdW = 5;
	localparam int PrioW = 8;
	localparam int TickW = 32;

	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_REMOVE = 2'd1;
	localparam logic [1:0] KIND_NEXT = 2'd2;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_MISSING = 2'd2;
	localparam logic [1:0] ST_DUP = 2'd3;

	typedef struct packed {
		logic [IdW-1:0] id;
		logic [PrioW-1:0] prio;
		logic rt;
		logic [TickW-1:0] dl;
		logic [TickW-1:0] rel;
	} entry_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [IdW-1:0] task_id;
		logic [PrioW-1:0] priority_req;
		logic rt_req;
		logic [TickW-1:0] deadline;
		logic [TickW-1:0] release_time;
		logic [TickW-1:0] now_tick;
	} req_t;
endpackage

// ===== rtl/peq_if.sv =====
// Valid/ready channel interface carrying one payload.
interface peq_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/peq_rsp_t.sv =====
// Result item type of the priority EDF ready queue.
package peq_rsp_pkg;
	typedef struct packed {
		logic [4:0] head_id;
		logic go_idle;
		logic [1:0] status;
		logic [5:0] occupancy;
	} rsp_t;
endpackage

// ===== rtl/priority_edf_ready_queue_unit.sv =====
// Top level of the priority EDF ready queue.
// Sorted ready queue held in one single-port-read memory of QUEUE_DEPTH entries with a
// registered read port. One item is worked at a time. Insert and remove first scan the
// occupied entries one a cycle to find the id and the position. An insert that is neither
// a duplicate nor full then moves each entry behind the position back one place through a
// read, a write and a check; remove moves the entries behind the removed one forward with
// a read and a write each. Get next reads the head only and its result is registered in
// the cycle after acceptance; an unused kind answers at the accepting edge. A result waits
// in an output register; the next item is accepted once that register is free.
module priority_edf_ready_queue_unit #(
	parameter int QUEUE_DEPTH = 32
) (
	input logic clk,
	input logic arst_n,
	peq_if.sink in_ch,
	peq_if.source out_ch
);
	import peq_pkg::*;
	import peq_rsp_pkg::*;

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_SHR = 3'd2;
	localparam logic [2:0] S_SHW = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;
	localparam logic [2:0] S_HEAD = 3'd5;
	localparam logic [2:0] S_REMR = 3'd6;
	localparam logic [2:0] S_REMW = 3'd7;

	entry_t mem [QUEUE_DEPTH];
	entry_t rd_q;
	logic [AW-1:0] raddr;
	logic re;
	logic we;
	logic [AW-1:0] waddr;
	entry_t wdata;

	logic [2:0] state_q;
	req_t req_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] pos_q;
	logic pos_found_q;
	logic id_found_q;
	logic [CW-1:0] id_pos_q;
	logic pend_q;
	logic [CW-1:0] sh_q;
	rsp_t rsp_q;
	logic out_v_q;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rd_q <= mem[raddr];
	end

	logic [CW-1:0] pidx;
	logic goes_before;
	assign pidx = idx_q - CW'(1);
	always_comb begin
		goes_before = (rd_q.prio > req_q.priority_req) ||
			((rd_q.prio == req_q.priority_req) && req_q.rt_req &&
			(!rd_q.rt || (req_q.deadline < rd_q.dl)));
	end

	entry_t new_e;
	assign new_e = '{id: req_q.task_id, prio: req_q.priority_req, rt: req_q.rt_req,
		dl: req_q.deadline, rel: req_q.release_time};

	assign in_ch.ready = (state_q == S_IDLE) && !out_v_q;
	assign out_ch.valid = out_v_q;
	assign out_ch.payload = rsp_q;

	always_comb begin
		re = 1'b0;
		raddr = '0;
		we = 1'b0;
		waddr = '0;
		wdata = rd_q;
		unique case (state_q)
			S_IDLE: begin
				re = 1'b1;
				raddr = '0;
			end
			S_SCAN: begin
				re = 1'b1;
				raddr = idx_q[AW-1:0];
			end
			S_SHR: begin
				re = 1'b1;
				raddr = AW'(sh_q - CW'(1));
			end
			S_SHW: begin
				we = 1'b1;
				waddr = sh_q[AW-1:0];
			end
			S_REMR: begin
				re = 1'b1;
				raddr = AW'(sh_q + CW'(1));
			end
			S_REMW: begin
				we = 1'b1;
				waddr = sh_q[AW-1:0];
			end
			S_DONE: begin
				// write the new entry only once the tail has moved clear of its slot
				we = (req_q.kind == KIND_INSERT) && !id_found_q &&
					(count_q < CW'(QUEUE_DEPTH)) && !(sh_q > pos_q);
				waddr = pos_q[AW-1:0];
				wdata = new_e;
			end
			S_HEAD: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			out_v_q <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) out_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						req_q <= in_ch.payload;
						idx_q <= '0;
						pend_q <= 1'b0;
						pos_found_q <= 1'b0;
						id_found_q <= 1'b0;
						unique case (in_ch.payload.kind)
							KIND_INSERT, KIND_REMOVE: state_q <= S_SCAN;
							KIND_NEXT: state_q <= S_HEAD;
							default: begin
								rsp_q <= '{head_id: '0, go_idle: 1'b0, status: ST_OK,
									occupancy: 6'(count_q)};
								out_v_q <= 1'b1;
							end
						endcase
					end
				end
				S_HEAD: begin
					rsp_q.status <= ST_OK;
					rsp_q.occupancy <= 6'(count_q);
					if (count_q == '0 || (rd_q.rt && req_q.now_tick < rd_q.rel)) begin
						rsp_q.head_id <= '0;
						rsp_q.go_idle <= 1'b1;
					end else begin
						rsp_q.head_id <= rd_q.id;
						rsp_q.go_idle <= 1'b0;
					end
					out_v_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_SCAN: begin
					// examine entry idx-1 (read issued last cycle)
					if (pend_q && pidx < count_q) begin
						if (rd_q.id == req_q.task_id && !id_found_q) begin
							id_found_q <= 1'b1;
							id_pos_q <= pidx;
						end
						if (!pos_found_q && goes_before) begin
							pos_found_q <= 1'b1;
							pos_q <= pidx;
						end
					end
					pend_q <= 1'b1;
					if (idx_q == count_q) begin
						state_q <= S_DONE;
						if (!pos_found_q && !(pend_q && pidx < count_q && goes_before))
							pos_q <= count_q;
						sh_q <= count_q;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				S_DONE: begin
					if (req_q.kind == KIND_INSERT) begin
						if (id_found_q) begin
							rsp_q <= '{head_id: '0, go_idle: 1'b0, status: ST_DUP,
								occupancy: 6'(count_q)};
							out_v_q <= 1'b1;
							state_q <= S_IDLE;
						end else if (count_q >= CW'(QUEUE_DEPTH)) begin
							rsp_q <= '{head_id: '0, go_idle: 1'b0, status: ST_FULL,
								occupancy: 6'(count_q)};
							out_v_q <= 1'b1;
							state_q <= S_IDLE;
						end else if (sh_q > pos_q) begin
							// slot not ready: shift tail back first
							state_q <= S_SHR;
						end else begin
							count_q <= count_q + CW'(1);
							rsp_q <= '{head_id: '0, go_idle: 1'b0, status: ST_OK,
								occupancy: 6'(count_q + CW'(1))};
							out_v_q <= 1'b1;
							state_q <= S_IDLE;
						end
					end else begin
						if (!id_found_q) begin
							rsp_q <= '{head_id: '0, go_idle: 1'b0, status: ST_MISSING,
								occupancy: 6'(count_q)};
							out_v_q <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							sh_q <= id_pos_q;
							state_q <= S_REMR;
						end
					end
				end
				S_SHR: state_q <= S_SHW;
				S_SHW: begin
					sh_q <= sh_q - CW'(1);
					state_q <= S_DONE;
				end
				S_REMR: begin
					if (sh_q + CW'(1) >= count_q) begin
						count_q <= count_q - CW'(1);
						rsp_q <= '{head_id: '0, go_idle: 1'b0, status: ST_OK,
							occupancy: 6'(count_q - CW'(1))};
						out_v_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_REMW;
					end
				end
				S_REMW: begin
					sh_q <= sh_q + CW'(1);
					state_q <= S_REMR;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
